[src/retransmit_wait_ack_queue_assert.svh]
// assertion macros shared by the retransmit queue modules
`ifndef RETRANSMIT_WAIT_ACK_QUEUE_ASSERT_SVH
`define RETRANSMIT_WAIT_ACK_QUEUE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define RWAQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define RWAQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/rwaq_pkg.sv]
// shared types and constants of the retransmit queue
package rwaq_pkg;

	localparam int QUEUE_DEPTH = 5;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);

	localparam int CNT_W  = 24;
	localparam int IV_W   = 16;
	localparam int REP_W  = 8;
	localparam int DLY_W  = 16;
	localparam int CMD_W  = 8;
	localparam int HDL_W  = 4;
	localparam int ADDR_W = 16;
	localparam int EV_W   = 2;

	localparam int DIV_STEPS  = CNT_W;
	localparam int DIV_STEP_W = $clog2(DIV_STEPS + 1);

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DELAY    = 2'd2;

	localparam logic [REP_W-1:0] REP_RESET = 8'd3;
	localparam logic [IV_W-1:0]  IV_RESET  = 16'd2000;
	localparam logic [DLY_W-1:0] DLY_RESET = 16'd0;

	localparam logic [ADDR_W-1:0] BROADCAST_ADDR = 16'hFFFF;

	localparam logic [EV_W-1:0] EV_TRANSMIT = 2'd0;
	localparam logic [EV_W-1:0] EV_TIMEOUT  = 2'd1;
	localparam logic [EV_W-1:0] EV_FULL     = 2'd2;

	typedef struct packed {
		logic [CNT_W-1:0] cnt;
		logic [CNT_W-1:0] wend;
		logic [IV_W-1:0]  iv;
		logic [CMD_W-1:0] cmd;
		logic [HDL_W-1:0] hdl;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic shift;
		logic place;
		logic div_start;
		logic apply;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic head_zero;
		logic full;
		logic div_done;
		logic out_busy;
		logic apply_emits;
	} dpath_stat_t;

endpackage

[src/rwaq_rem.sv]
// serial restoring remainder unit, one quotient bit per cycle
module rwaq_rem
	import rwaq_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [CNT_W-1:0] dividend,
	input  logic [IV_W-1:0]  divisor,
	output logic             done,
	output logic             rem_zero
);

	logic                  busy_q;
	logic                  done_q;
	logic [DIV_STEP_W-1:0] step_q;
	logic [CNT_W-1:0]      dvd_q;
	logic [IV_W-1:0]       dsr_q;
	logic [IV_W-1:0]       rem_q;
	logic [IV_W:0]         trial;
	logic [IV_W:0]         diff;
	logic                  ge;

	assign trial = {rem_q, dvd_q[CNT_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign ge    = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= DIV_STEP_W'(DIV_STEPS);
			end else if (busy_q) begin
				step_q <= step_q - DIV_STEP_W'(1);
				if (step_q == DIV_STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[CNT_W-2:0], 1'b0};
			rem_q <= ge ? diff[IV_W-1:0] : trial[IV_W-1:0];
		end
	end

	assign done     = done_q;
	assign rem_zero = (rem_q == '0);

`include "retransmit_wait_ack_queue_assert.svh"

	`RWAQ_ASSERT_NOW(a_rem_bound, clk, arst_n, busy_q && (dsr_q != '0), rem_q < dsr_q, "partial remainder not below divisor")
	`RWAQ_ASSERT_NEXT(a_done_once, clk, arst_n, done_q, !done_q && !busy_q, "remainder done held over cycles")

endmodule

[src/rwaq_dpath.sv]
// retransmit table, configuration, span product and result register
module rwaq_dpath
	import rwaq_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctrl_cmd_t             cmd,
	output dpath_stat_t           stat,
	input  logic [ADDR_W-1:0]     in_dest,
	input  logic [CMD_W-1:0]      in_cmd,
	input  logic [HDL_W-1:0]      in_hdl,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  m_valid,
	input  logic                  m_ready,
	output logic [EV_W-1:0]       m_ev,
	output logic [HDL_W-1:0]      m_hdl,
	output logic [CMD_W-1:0]      m_cmd,
	output logic                  m_ack
);

	entry_t            tbl_q [QUEUE_DEPTH];
	logic [REP_W-1:0]  rep_q;
	logic [IV_W-1:0]   iv_q;
	logic [DLY_W-1:0]  dly_q;
	logic              bcast_q;
	logic [ADDR_W-1:0] dest_q;
	logic [CMD_W-1:0]  cmd_q;
	logic [HDL_W-1:0]  hdl_q;
	logic [CNT_W-1:0]  span_q;

	logic              out_valid_q;
	logic [EV_W-1:0]   out_ev_q;
	logic [HDL_W-1:0]  out_hdl_q;
	logic [CMD_W-1:0]  out_cmd_q;
	logic              out_ack_q;

	logic [QUEUE_DEPTH-2:0] copy_en;
	logic [IDX_W-1:0]       free_idx;
	logic                   found;
	logic [CNT_W-1:0]       cnt_dec;
	logic                   send;
	logic                   rem_done;
	logic                   rem_zero;

	// entry i takes entry i+1 while no zero count has been met from entry 1 on
	always_comb begin
		copy_en[0] = 1'b1;
		for (int i = 1; i < QUEUE_DEPTH - 1; i++) begin
			copy_en[i] = copy_en[i-1] & (tbl_q[i].cnt != '0);
		end
	end

	// first free slot among all but the last
	always_comb begin
		found    = 1'b0;
		free_idx = '0;
		for (int i = QUEUE_DEPTH - 2; i >= 0; i--) begin
			if (tbl_q[i].cnt == '0) begin
				found    = 1'b1;
				free_idx = IDX_W'(i);
			end
		end
	end

	rwaq_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (tbl_q[0].cnt),
		.divisor  (tbl_q[0].iv),
		.done     (rem_done),
		.rem_zero (rem_zero)
	);

	assign cnt_dec = tbl_q[0].cnt - CNT_W'(1);
	assign send    = (tbl_q[0].iv != '0) && rem_zero && (tbl_q[0].cnt <= tbl_q[0].wend);

	always_comb begin
		stat.head_zero   = (tbl_q[0].cnt == '0);
		stat.full        = !found;
		stat.div_done    = rem_done;
		stat.out_busy    = out_valid_q;
		stat.apply_emits = (cnt_dec == '0) || send;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rep_q <= REP_RESET;
			iv_q  <= IV_RESET;
			dly_q <= DLY_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_REPEAT:   rep_q <= cfg_data[REP_W-1:0];
				CFG_INTERVAL: iv_q  <= cfg_data[IV_W-1:0];
				CFG_DELAY:    dly_q <= cfg_data[DLY_W-1:0];
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			dest_q <= in_dest;
			cmd_q  <= in_cmd;
			hdl_q  <= in_hdl;
		end
		if (cmd.shift) begin
			span_q <= CNT_W'(rep_q) * CNT_W'(iv_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QUEUE_DEPTH; i++) begin
				tbl_q[i] <= '0;
			end
			bcast_q <= 1'b0;
		end else begin
			if (cmd.shift) begin
				bcast_q <= (dest_q == BROADCAST_ADDR);
				for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
					if (copy_en[i]) begin
						tbl_q[i] <= tbl_q[i+1];
					end
				end
			end
			if (cmd.place && found) begin
				tbl_q[free_idx].cnt  <= span_q + CNT_W'(dly_q);
				tbl_q[free_idx].wend <= span_q;
				tbl_q[free_idx].iv   <= iv_q;
				tbl_q[free_idx].cmd  <= cmd_q;
				tbl_q[free_idx].hdl  <= hdl_q;
			end
			if (cmd.apply) begin
				if (cnt_dec == '0) begin
					for (int i = 0; i < QUEUE_DEPTH; i++) begin
						tbl_q[i] <= '0;
					end
				end else begin
					tbl_q[0].cnt <= cnt_dec;
				end
			end
		end
	end

	// result register: loaded only when empty, the controller sees to that
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_ready) begin
				out_valid_q <= 1'b0;
			end
			if ((cmd.place && !found) || (cmd.apply && stat.apply_emits)) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.place && !found) begin
			out_ev_q  <= EV_FULL;
			out_hdl_q <= hdl_q;
			out_cmd_q <= cmd_q;
			out_ack_q <= 1'b0;
		end else if (cmd.apply && stat.apply_emits) begin
			out_ev_q  <= (cnt_dec == '0) ? EV_TIMEOUT : EV_TRANSMIT;
			out_hdl_q <= tbl_q[0].hdl;
			out_cmd_q <= tbl_q[0].cmd;
			out_ack_q <= (cnt_dec == '0) ? bcast_q : 1'b0;
		end
	end

	assign m_valid = out_valid_q;
	assign m_ev    = out_ev_q;
	assign m_hdl   = out_hdl_q;
	assign m_cmd   = out_cmd_q;
	assign m_ack   = out_ack_q;

`include "retransmit_wait_ack_queue_assert.svh"

	`RWAQ_ASSERT_NEXT(a_timeout_clears, clk, arst_n, cmd.apply && (cnt_dec == '0), tbl_q[0].cnt == '0, "head not cleared after timeout")

endmodule

[src/rwaq_ctrl.sv]
// sequencing state machine of the retransmit queue
module rwaq_ctrl
	import rwaq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_kind,
	output logic        in_ready,
	input  dpath_stat_t stat,
	output ctrl_cmd_t   cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SHIFT = 3'd1;
	localparam logic [2:0] S_PLACE = 3'd2;
	localparam logic [2:0] S_TCHK  = 3'd3;
	localparam logic [2:0] S_DIV   = 3'd4;
	localparam logic [2:0] S_APPLY = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = in_kind ? S_SHIFT : S_TCHK;
				end
			end
			S_SHIFT: begin
				cmd.shift = 1'b1;
				state_d   = S_PLACE;
			end
			S_PLACE: begin
				if (!stat.full || !stat.out_busy) begin
					cmd.place = 1'b1;
					state_d   = S_IDLE;
				end
			end
			S_TCHK: begin
				if (stat.head_zero) begin
					state_d = S_IDLE;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end
			end
			S_DIV: begin
				if (stat.div_done) begin
					state_d = S_APPLY;
				end
			end
			S_APPLY: begin
				if (!stat.apply_emits || !stat.out_busy) begin
					cmd.apply = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`include "retransmit_wait_ack_queue_assert.svh"

	`RWAQ_ASSERT_NOW(a_emit_free, clk, arst_n, (cmd.place && stat.full) || (cmd.apply && stat.apply_emits), !stat.out_busy, "result issued into occupied output")
	`RWAQ_ASSERT_NEXT(a_start_wait, clk, arst_n, cmd.div_start, state_q == S_DIV && !stat.div_done, "remainder started outside wait")

endmodule

[src/retransmit_wait_ack_queue.sv]
// top level of the retransmit scheduler for unacknowledged packets
//
// channel   dir  handshake              payload
// s_axis    in   tvalid/tready          tuser: kind; tdata: dest, command, handle
// m_axis    out  tvalid/tready          tuser: event; tdata: handle, command, ack
// cfg       in   cfg_we (no wait)       cfg_index, cfg_data
//
// a submit runs through accept, table shift with span product, and slot placement
// a tick on an empty head goes straight back to idle; otherwise it waits on the
// 24-step serial remainder unit that tests the count against the interval
// reset clears the table, the broadcast flag and the state machine at once
// a new item is taken while a result still waits in the output register; the
// controller only holds when it must load a result and the register is full
module retransmit_wait_ack_queue
	import rwaq_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [31:0]           s_axis_tdata,  // dest_address, command_code, packet_handle
	input  logic [0:0]            s_axis_tuser,  // kind
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [15:0]           m_axis_tdata,  // out_handle, out_command, ack_status
	output logic [1:0]            m_axis_tuser,  // event_res
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	ctrl_cmd_t   cmd;
	dpath_stat_t stat;
	logic [HDL_W-1:0] m_hdl;
	logic [CMD_W-1:0] m_cmd;
	logic             m_ack;

	// sequencer: one item at a time
	rwaq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_kind  (s_axis_tuser[0]),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// table, registers, remainder unit and output register
	rwaq_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_dest   (s_axis_tdata[15:0]),
		.in_cmd    (s_axis_tdata[23:16]),
		.in_hdl    (s_axis_tdata[27:24]),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_valid   (m_axis_tvalid),
		.m_ready   (m_axis_tready),
		.m_ev      (m_axis_tuser),
		.m_hdl     (m_hdl),
		.m_cmd     (m_cmd),
		.m_ack     (m_ack)
	);

	// result transfer payload, padded to whole bytes
	assign m_axis_tdata = {3'b000, m_ack, m_cmd, m_hdl};

endmodule

[tb/tb_retransmit_wait_ack_queue.sv]
// testbench for the retransmit scheduler: directed and random stream traffic checked against a local predictor
module tb_retransmit_wait_ack_queue;
	import rwaq_pkg::*;

	// item kinds carried in tuser on the input side
	localparam logic KIND_TICK   = 1'b0;
	localparam logic KIND_SUBMIT = 1'b1;

	// quiet cycles after the last result before touching the registers or ending
	localparam int SETTLE_CYCLES = 64;
	// length of the long receiver hold-off
	localparam int HOLD_CYCLES   = 2000;
	// overall run limit, far beyond the slowest correct run
	localparam int RUN_LIMIT     = 30_000_000;

	typedef struct {
		logic              kind;
		logic [ADDR_W-1:0] dest;
		logic [CMD_W-1:0]  command;
		logic [HDL_W-1:0]  handle;
	} sched_item_t;

	typedef struct {
		logic [EV_W-1:0]  ev;
		logic [HDL_W-1:0] handle;
		logic [CMD_W-1:0] command;
		logic             ack;
	} sched_event_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [31:0]           s_axis_tdata = '0;  // dest_address, command_code, packet_handle
	logic [0:0]            s_axis_tuser = '0;  // kind
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [15:0]           m_axis_tdata;       // out_handle, out_command, ack_status
	logic [1:0]            m_axis_tuser;       // event_res
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	retransmit_wait_ack_queue dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #10 clk = ~clk;

	// items waiting to be offered, and events the block still owes us
	sched_item_t  pending_items[$];
	sched_event_t expected_events[$];
	int           mismatches = 0;

	// idle percentages of both sides, changed only at falling edges
	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;

	// hold-off requests from the stimulus, served by the receiver process
	int unsigned holds_asked = 0;
	int unsigned holds_served;
	int unsigned rx_hold_left;

	// predictor copy of the registers, in step with what was written
	logic [REP_W-1:0] repeat_cfg   = REP_RESET;
	logic [IV_W-1:0]  interval_cfg = IV_RESET;
	logic [DLY_W-1:0] delay_cfg    = DLY_RESET;

	// predictor copy of the schedule table, slot 0 is the head
	logic [CNT_W-1:0] slot_count [QUEUE_DEPTH];
	logic [CNT_W-1:0] slot_wend  [QUEUE_DEPTH];
	logic [IV_W-1:0]  slot_iv    [QUEUE_DEPTH];
	logic [CMD_W-1:0] slot_cmd   [QUEUE_DEPTH];
	logic [HDL_W-1:0] slot_hdl   [QUEUE_DEPTH];
	logic             sent_broadcast = 1'b0;

	initial begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			slot_count[i] = '0;
			slot_wend[i]  = '0;
			slot_iv[i]    = '0;
			slot_cmd[i]   = '0;
			slot_hdl[i]   = '0;
		end
	end

	function automatic void owe_event(input logic [EV_W-1:0] ev, input logic [HDL_W-1:0] hdl,
			input logic [CMD_W-1:0] cmd, input logic ack);
		sched_event_t e;
		e.ev      = ev;
		e.handle  = hdl;
		e.command = cmd;
		e.ack     = ack;
		expected_events.push_back(e);
	endfunction

	// one accepted item moves the table on and may owe one event
	function automatic void advance_schedule(input sched_item_t it);
		int i;
		int slot;
		logic [31:0] span;
		logic [CNT_W-1:0] left;
		logic send;
		if (it.kind == KIND_SUBMIT) begin
			sent_broadcast = (it.dest == BROADCAST_ADDR);
			// head goes, the chain of busy entries moves down by one
			for (i = 0; i < QUEUE_DEPTH - 1; i++) begin
				slot_count[i] = slot_count[i + 1];
				slot_wend[i]  = slot_wend[i + 1];
				slot_iv[i]    = slot_iv[i + 1];
				slot_cmd[i]   = slot_cmd[i + 1];
				slot_hdl[i]   = slot_hdl[i + 1];
				if (slot_count[i + 1] == 0)
					break;
			end
			slot = 0;
			while (slot < QUEUE_DEPTH - 1 && slot_count[slot] != 0)
				slot++;
			if (slot == QUEUE_DEPTH - 1) begin
				owe_event(EV_FULL, it.handle, it.command, 1'b0);
			end else begin
				span = repeat_cfg * interval_cfg;
				slot_count[slot] = CNT_W'(span + delay_cfg);
				slot_wend[slot]  = CNT_W'(span);
				slot_iv[slot]    = interval_cfg;
				slot_cmd[slot]   = it.command;
				slot_hdl[slot]   = it.handle;
			end
		end else if (slot_count[0] != 0) begin
			send = 1'b0;
			if (slot_iv[0] != 0)
				send = (slot_count[0] % slot_iv[0] == 0) && (slot_count[0] <= slot_wend[0]);
			left = slot_count[0] - 1'b1;
			slot_count[0] = left;
			if (left == 0) begin
				// a timeout hides a transmission due on the same tick
				owe_event(EV_TIMEOUT, slot_hdl[0], slot_cmd[0], sent_broadcast);
				for (i = 0; i < QUEUE_DEPTH; i++) begin
					slot_count[i] = '0;
					slot_wend[i]  = '0;
					slot_iv[i]    = '0;
					slot_cmd[i]   = '0;
					slot_hdl[i]   = '0;
				end
			end else if (send) begin
				owe_event(EV_TRANSMIT, slot_hdl[0], slot_cmd[0], 1'b0);
			end
		end
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// input driver: a new transfer is offered only once the previous one has gone
	always @(posedge clk or negedge arst_n) begin
		sched_item_t nxt;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= '0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (pending_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				nxt = pending_items.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= {4'b0, nxt.handle, nxt.command, nxt.dest};
				s_axis_tuser  <= nxt.kind;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// output receiver: random stalls, plus the long hold-off when one is asked
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_hold_left  <= 0;
			holds_served  <= 0;
		end else if (holds_served != holds_asked) begin
			holds_served  <= holds_asked;
			rx_hold_left  <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (rx_hold_left != 0) begin
			rx_hold_left  <= rx_hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// monitor: result transfers are checked, input transfers feed the predictor
	always @(posedge clk) begin
		sched_event_t want;
		sched_item_t  taken;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_events.size() == 0) begin
					$error("unexpected result: event_res %0d out_handle %0d out_command %0d",
						m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[11:4]);
					mismatches++;
				end else begin
					want = expected_events.pop_front();
					check_field("event_res", want.ev, m_axis_tuser);
					check_field("out_handle", want.handle, m_axis_tdata[3:0]);
					check_field("out_command", want.command, m_axis_tdata[11:4]);
					check_field("ack_status", want.ack, m_axis_tdata[12]);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				taken.kind    = s_axis_tuser[0];
				taken.dest    = s_axis_tdata[15:0];
				taken.command = s_axis_tdata[23:16];
				taken.handle  = s_axis_tdata[27:24];
				advance_schedule(taken);
			end
		end
	end

	// run limit
	initial begin
		#(RUN_LIMIT);
		$display("status: fail");
		$finish;
	end

	task automatic queue_item(input logic kind, input logic [ADDR_W-1:0] dest,
			input logic [CMD_W-1:0] cmd, input logic [HDL_W-1:0] hdl);
		sched_item_t it;
		it.kind    = kind;
		it.dest    = dest;
		it.command = cmd;
		it.handle  = hdl;
		pending_items.push_back(it);
	endtask

	// tick fields carry noise, the block must ignore them
	task automatic queue_tick();
		queue_item(KIND_TICK, 16'($urandom), 8'($urandom), 4'($urandom));
	endtask

	// everything sent, everything received, then let the block settle
	task automatic wait_drained();
		@(negedge clk);
		while (pending_items.size() != 0 || s_axis_tvalid || expected_events.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register writes happen only with the block idle
	task automatic set_schedule_regs(input logic [REP_W-1:0] rep, input logic [IV_W-1:0] iv,
			input logic [DLY_W-1:0] dly);
		wait_drained();
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_REPEAT;
		cfg_data  <= CFG_DATA_W'(rep);
		@(posedge clk);
		cfg_index <= CFG_INTERVAL;
		cfg_data  <= iv;
		@(posedge clk);
		cfg_index <= CFG_DELAY;
		cfg_data  <= dly;
		@(posedge clk);
		cfg_we       <= 1'b0;
		repeat_cfg   = rep;
		interval_cfg = iv;
		delay_cfg    = dly;
		@(negedge clk);
	endtask

	// mostly a submit followed by enough ticks to run the entry out, some cut short,
	// the rest loose noise; ticks on an empty head are not counted
	task automatic queue_random_phase(input int budget);
		int spent;
		int span;
		int ticks;
		logic [ADDR_W-1:0] dest;
		spent = 0;
		while (spent < budget) begin
			if ($urandom_range(99) < 85) begin
				dest = ($urandom_range(3) == 0) ? BROADCAST_ADDR : 16'($urandom);
				queue_item(KIND_SUBMIT, dest, 8'($urandom), 4'($urandom));
				span = int'(repeat_cfg) * int'(interval_cfg) + int'(delay_cfg);
				if (span == 0)
					ticks = $urandom_range(0, 1);
				else if (span <= 300)
					ticks = ($urandom_range(9) == 0) ? $urandom_range(0, span - 1)
						: $urandom_range(span, span + 2);
				else
					ticks = $urandom_range(1, 24);
				repeat (ticks) queue_tick();
				spent += 1 + ((ticks < span) ? ticks : span);
			end else begin
				queue_item(1'($urandom), 16'($urandom), 8'($urandom), 4'($urandom));
				spent++;
			end
		end
	endtask

	initial begin
		int mode;
		int p;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: count 6000 is a multiple of 2000, so the first tick transmits
		queue_item(KIND_SUBMIT, BROADCAST_ADDR, 8'hFF, 4'hF);
		queue_tick();
		queue_item(KIND_SUBMIT, 16'h0000, 8'h00, 4'h0);
		queue_tick();
		queue_tick();

		// interval one: transmission and timeout fall together, only the timeout shows
		set_schedule_regs(8'd1, 16'd1, 16'd0);
		queue_item(KIND_SUBMIT, 16'hFFFE, 8'h5A, 4'h9);
		queue_tick();
		queue_item(KIND_SUBMIT, BROADCAST_ADDR, 8'hA5, 4'h6);
		queue_tick();
		queue_tick();   // empty head

		// zero count at submit: stored as free, never acts
		set_schedule_regs(8'd0, 16'hFFFF, 16'd0);
		queue_item(KIND_SUBMIT, 16'h1234, 8'h3C, 4'h3);
		queue_tick();

		// zero interval: no transmission, only the countdown to timeout
		set_schedule_regs(8'd2, 16'd0, 16'd3);
		queue_item(KIND_SUBMIT, 16'h8001, 8'hC3, 4'hC);
		repeat (3) queue_tick();

		// largest settings: count sits above the window, nothing due yet
		set_schedule_regs(8'd255, 16'hFFFF, 16'hFFFF);
		queue_item(KIND_SUBMIT, 16'h7FFF, 8'h81, 4'h8);
		queue_tick();

		// no extra delay: the first tick is at the window end and transmits
		set_schedule_regs(8'd255, 16'hFFFF, 16'd0);
		queue_item(KIND_SUBMIT, BROADCAST_ADDR, 8'h7E, 4'h1);
		queue_tick();

		// random part: sender and receiver idle rates swap, then neither idles
		for (mode = 0; mode < 3; mode++) begin
			for (p = 0; p < 9; p++) begin
				case (p)
					0: set_schedule_regs(8'd255, 16'hFFFF, 16'hFFFF);
					1: set_schedule_regs(8'd0, 16'd1, 16'd0);
					2: set_schedule_regs(8'd1, 16'd1, 16'd0);
					3: set_schedule_regs(8'd255, 16'd1, 16'd0);
					4: set_schedule_regs(8'($urandom_range(1, 6)), 16'd0, 16'($urandom_range(1, 8)));
					default: set_schedule_regs(8'($urandom_range(0, 6)),
						16'($urandom_range(1, 6)), 16'($urandom_range(0, 8)));
				endcase
				// idle rates only change while the block is quiet
				tx_idle_pct = (mode == 0) ? 16 : (mode == 1) ? 76 : 0;
				rx_idle_pct = (mode == 0) ? 76 : (mode == 1) ? 16 : 0;
				// uncounted ticks and the long window phase add to this
				queue_random_phase(28);
			end
		end

		// every tick on a busy head owes a result here, so a long receiver hold-off
		// backs results up until the input side stalls
		set_schedule_regs(8'd6, 16'd1, 16'd0);
		holds_asked = holds_asked + 1;
		queue_random_phase(60);

		wait_drained();
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

[sim.f]
+incdir+src
src/rwaq_pkg.sv
src/rwaq_rem.sv
src/rwaq_dpath.sv
src/rwaq_ctrl.sv
src/retransmit_wait_ack_queue.sv
tb/tb_retransmit_wait_ack_queue.sv
